/* rtl/t64p_pkg.sv */
// ----------------------------------------------------------------------------
// t64p_pkg
// shared types and constants of the text to u64 parser
// ----------------------------------------------------------------------------
package t64p_pkg;

	localparam int CHAR_W = 8;
	localparam int BASE_W = 6;
	localparam int VALUE_W = 64;
	localparam int POS_W = 12;
	localparam int STATUS_W = 2;

	localparam int MAX_TEXT_LEN = 4096;
	localparam int POS_LIMIT_I = ((MAX_TEXT_LEN - 1) < 4095) ? (MAX_TEXT_LEN - 1) : 4095;
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_LIMIT_I);

	localparam logic [BASE_W-1:0] MAX_BASE = 6'd36;
	localparam logic [BASE_W-1:0] NO_DIGIT = 6'd36;
	localparam logic [BASE_W-1:0] BASE_OCT = 6'd8;
	localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;
	localparam logic [BASE_W-1:0] BASE_HEX = 6'd16;

	localparam int MID_DEPTH_DEF = 4;
	localparam int OUT_DEPTH_DEF = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_BAD_BASE = 2'd2
	} status_t;

	// classified character word
	typedef struct packed {
		logic              term;
		logic              space;
		logic              minus;
		logic              plus;
		logic              zero_ch;
		logic              x_ch;
		logic [BASE_W-1:0] digit;
		logic [POS_W-1:0]  next_pos;
	} tok_t;

	// result word
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic               digits;
		logic [POS_W-1:0]   stop;
	} res_t;

endpackage

/* rtl/t64p_fifo.sv */
// ----------------------------------------------------------------------------
// t64p_fifo
// small register queue with push/full and pop/empty
// ----------------------------------------------------------------------------
module t64p_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/t64p_front.sv */
// ----------------------------------------------------------------------------
// t64p_front
// classifies each accepted character and tracks its position in the string
// ----------------------------------------------------------------------------
module t64p_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [t64p_pkg::CHAR_W-1:0]  char_code,
	output t64p_pkg::tok_t               tok
);

	logic [t64p_pkg::POS_W-1:0] pos_q;
	logic [t64p_pkg::POS_W-1:0] pos_next;
	logic                       is_term;

	assign is_term  = (char_code == 8'd0);
	assign pos_next = (pos_q >= t64p_pkg::POS_LIMIT) ? t64p_pkg::POS_LIMIT : pos_q + 1'b1;

	always_comb begin
		tok          = '0;
		tok.term     = is_term;
		tok.space    = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
		tok.minus    = (char_code == 8'd45);
		tok.plus     = (char_code == 8'd43);
		tok.zero_ch  = (char_code == 8'd48);
		tok.x_ch     = (char_code == 8'd120) || (char_code == 8'd88);
		tok.next_pos = pos_next;
		priority if (char_code >= 8'd48 && char_code <= 8'd57) begin
			tok.digit = t64p_pkg::BASE_W'(char_code - 8'd48);
		end else if (char_code >= 8'd97 && char_code <= 8'd122) begin
			tok.digit = t64p_pkg::BASE_W'(char_code - 8'd87);
		end else if (char_code >= 8'd65 && char_code <= 8'd90) begin
			tok.digit = t64p_pkg::BASE_W'(char_code - 8'd55);
		end else begin
			tok.digit = t64p_pkg::NO_DIGIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			pos_q <= is_term ? '0 : pos_next;
		end
	end

endmodule

/* rtl/t64p_back.sv */
// ----------------------------------------------------------------------------
// t64p_back
// parse sequencer: sign, base prefix, digit multiply-add and result forming
// ----------------------------------------------------------------------------
module t64p_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [t64p_pkg::BASE_W-1:0]  cfg_base,
	input  logic                         tok_valid,
	input  t64p_pkg::tok_t               tok,
	output logic                         tok_take,
	input  logic                         res_full,
	output logic                         res_push,
	output t64p_pkg::res_t               res
);

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_TAIL
	} phase_t;

	localparam int PW = t64p_pkg::VALUE_W + t64p_pkg::BASE_W;

	phase_t                        phase_q, phase_n;
	logic                          minus_q, minus_n;
	logic [t64p_pkg::BASE_W-1:0]   base_q, base_n;
	logic [t64p_pkg::VALUE_W-1:0]  acc_q, acc_n;
	logic                          ovf_q, ovf_n;
	logic                          dig_q, dig_n;
	logic [t64p_pkg::POS_W-1:0]    stop_q, stop_n;

	logic [t64p_pkg::BASE_W-1:0]   base_eff;
	logic [t64p_pkg::BASE_W-1:0]   td_base;
	logic                          base_bad;
	logic                          td_ok;
	logic                          do_as;
	logic                          do_td;
	logic [PW-1:0]                 prod;

	assign tok_take = tok_valid && !res_full;
	assign base_eff = (phase_q == PH_SPACE) ? cfg_base : base_q;
	assign base_bad = (base_eff == 6'd1) || (base_eff > t64p_pkg::MAX_BASE);
	assign td_base  = (phase_q == PH_ZERO) ? t64p_pkg::BASE_OCT :
		((base_eff == '0) ? t64p_pkg::BASE_DEC : base_eff);
	assign td_ok    = (td_base >= 6'd2) && (tok.digit < td_base);
	assign prod     = PW'(acc_q) * PW'(td_base) + PW'(tok.digit);

	always_comb begin
		phase_n  = phase_q;
		minus_n  = minus_q;
		base_n   = base_q;
		acc_n    = acc_q;
		ovf_n    = ovf_q;
		dig_n    = dig_q;
		stop_n   = stop_q;
		res_push = 1'b0;
		res      = '0;
		res.status = t64p_pkg::ST_OK;
		do_as    = 1'b0;
		do_td    = 1'b0;

		if (tok_take) begin
			if (tok.term) begin
				res_push = 1'b1;
				priority if (base_bad) begin
					res.status = t64p_pkg::ST_BAD_BASE;
				end else if (ovf_q) begin
					res.status = t64p_pkg::ST_OVERFLOW;
					res.digits = 1'b1;
					res.stop   = stop_q;
				end else if (dig_q) begin
					res.value  = minus_q ? (t64p_pkg::VALUE_W'(0) - acc_q) : acc_q;
					res.digits = 1'b1;
					res.stop   = stop_q;
				end else begin
				end
				phase_n = PH_SPACE;
				minus_n = 1'b0;
				base_n  = '0;
				acc_n   = '0;
				ovf_n   = 1'b0;
				dig_n   = 1'b0;
				stop_n  = '0;
			end else begin
				unique case (phase_q)
					PH_SPACE: begin
						if (!tok.space) begin
							base_n = cfg_base;
							priority if (tok.minus) begin
								minus_n = 1'b1;
								phase_n = PH_SIGNED;
							end else if (tok.plus) begin
								phase_n = PH_SIGNED;
							end else begin
								do_as = 1'b1;
							end
						end
					end
					PH_SIGNED: begin
						do_as = 1'b1;
					end
					PH_ZERO: begin
						if (tok.x_ch) begin
							base_n  = t64p_pkg::BASE_HEX;
							phase_n = PH_DIGITS;
						end else begin
							base_n = t64p_pkg::BASE_OCT;
							do_td  = 1'b1;
						end
					end
					PH_DIGITS: begin
						do_td = 1'b1;
					end
					default: begin
					end
				endcase

				if (do_as) begin
					priority if (base_bad) begin
						phase_n = PH_TAIL;
					end else if (base_eff == '0) begin
						if (tok.zero_ch) begin
							dig_n   = 1'b1;
							stop_n  = tok.next_pos;
							phase_n = PH_ZERO;
						end else begin
							base_n = t64p_pkg::BASE_DEC;
							do_td  = 1'b1;
						end
					end else begin
						do_td = 1'b1;
					end
				end

				if (do_td) begin
					if (!td_ok) begin
						phase_n = PH_TAIL;
					end else begin
						dig_n   = 1'b1;
						stop_n  = tok.next_pos;
						phase_n = PH_DIGITS;
						if (!ovf_q) begin
							ovf_n = (prod[PW-1:t64p_pkg::VALUE_W] != '0);
							acc_n = prod[t64p_pkg::VALUE_W-1:0];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			minus_q <= 1'b0;
			base_q  <= '0;
			acc_q   <= '0;
			ovf_q   <= 1'b0;
			dig_q   <= 1'b0;
			stop_q  <= '0;
		end else begin
			phase_q <= phase_n;
			minus_q <= minus_n;
			base_q  <= base_n;
			acc_q   <= acc_n;
			ovf_q   <= ovf_n;
			dig_q   <= dig_n;
			stop_q  <= stop_n;
		end
	end

endmodule

/* rtl/text_to_u64_parser_core.sv */
// ----------------------------------------------------------------------------
// text_to_u64_parser_core
// streaming text to 64-bit unsigned integer parser
// ----------------------------------------------------------------------------
// Takes one character word per cycle and keeps taking one per cycle as long as
// results are popped. A zero byte ends a string and yields one result word,
// which goes from the token queue through the parse sequencer into the result
// queue before it shows on the result ports. Each character is classified on
// entry, queued, and then handled by the parse sequencer, whose 64 by 6 bit
// multiply-add per digit sets the rate of one character per clock while the
// result queue has room. number_base may be written only while no string is
// in flight; base 0 picks the radix from the prefix, 1 or above 36 is
// rejected.
// ----------------------------------------------------------------------------
module text_to_u64_parser_core #(
	parameter int MID_DEPTH = t64p_pkg::MID_DEPTH_DEF,
	parameter int OUT_DEPTH = t64p_pkg::OUT_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [t64p_pkg::CHAR_W-1:0]    char_code,
	output logic                           empty,
	input  logic                           pop,
	output logic [t64p_pkg::VALUE_W-1:0]   parsed_value,
	output logic [t64p_pkg::STATUS_W-1:0]  status,
	output logic                           digits_found,
	output logic [t64p_pkg::POS_W-1:0]     stop_offset,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [t64p_pkg::BASE_W-1:0]    number_base
);

	localparam int TOK_W = $bits(t64p_pkg::tok_t);
	localparam int RES_W = $bits(t64p_pkg::res_t);

	logic [t64p_pkg::BASE_W-1:0] number_base_q;
	logic                        mid_full;
	logic                        mid_empty;
	logic                        accept;
	logic                        tok_take;
	logic                        res_full;
	logic                        res_push;
	t64p_pkg::tok_t              tok_in;
	t64p_pkg::tok_t              tok_out;
	t64p_pkg::res_t              res_in;
	t64p_pkg::res_t              res_out;

	assign cfg_ready = 1'b1;
	assign full      = mid_full;
	assign accept    = push && !mid_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			number_base_q <= number_base;
		end
	end

	t64p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_code (char_code),
		.tok       (tok_in)
	);

	t64p_fifo #(
		.WIDTH (TOK_W),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_data (tok_in),
		.full    (mid_full),
		.rd_en   (tok_take),
		.rd_data (tok_out),
		.empty   (mid_empty)
	);

	t64p_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_base  (number_base_q),
		.tok_valid (!mid_empty),
		.tok       (tok_out),
		.tok_take  (tok_take),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	t64p_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	assign parsed_value = res_out.value;
	assign status       = res_out.status;
	assign digits_found = res_out.digits;
	assign stop_offset  = res_out.stop;

endmodule

/* tb/t64p_checker.sv */
// ----------------------------------------------------------------------------
// t64p_checker
// scoreboard for the text to u64 parser core
// ----------------------------------------------------------------------------
// Watches the character, result and radix channels of the parser core. It
// keeps its own copy of the parse state and of number_base. Every accepted
// character runs through that copy. A terminator queues the result word that
// the core must give. Each popped word is compared field by field with the
// oldest queued one. It reports the number of words still outstanding and the
// number of failures.
// ----------------------------------------------------------------------------
module t64p_checker
	import t64p_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [CHAR_W-1:0]   char_code,
	input  logic                empty,
	input  logic                pop,
	input  logic [VALUE_W-1:0]  parsed_value,
	input  logic [STATUS_W-1:0] status,
	input  logic                digits_found,
	input  logic [POS_W-1:0]    stop_offset,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [BASE_W-1:0]   number_base,
	output int                  pending_count,
	output int                  fail_count,
	output int                  result_count
);

	localparam logic [CHAR_W-1:0] END_OF_TEXT = '0;

	typedef enum logic [2:0] {
		SCAN_LEAD,
		SCAN_SIGN,
		SCAN_ZERO,
		SCAN_DIGITS,
		SCAN_REST
	} scan_t;

	logic [BASE_W-1:0]  base_reg;
	scan_t              scan;
	logic               neg;
	logic [BASE_W-1:0]  radix;
	logic [VALUE_W-1:0] acc;
	logic               ovf;
	logic               got_digit;
	logic [POS_W-1:0]   char_pos;
	logic [POS_W-1:0]   stop_pos;
	res_t               words_due[$];
	int                 fails;
	int                 checked;

	function automatic logic [BASE_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
		if (c >= "0" && c <= "9")
			return BASE_W'(c - "0");
		if (c >= "a" && c <= "z")
			return BASE_W'(c - "a" + 10);
		if (c >= "A" && c <= "Z")
			return BASE_W'(c - "A" + 10);
		return NO_DIGIT;
	endfunction

	function automatic logic bad_radix(input logic [BASE_W-1:0] b);
		return b == 1 || b > MAX_BASE;
	endfunction

	function automatic logic [POS_W-1:0] pos_after(input logic [POS_W-1:0] p);
		return (p >= POS_LIMIT) ? POS_LIMIT : p + 1'b1;
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return c == " " || (c >= "\t" && c <= "\015");
	endfunction

	task automatic clear_text();
		scan = SCAN_LEAD;
		neg = 1'b0;
		radix = '0;
		acc = '0;
		ovf = 1'b0;
		got_digit = 1'b0;
		char_pos = '0;
		stop_pos = '0;
	endtask

	task automatic take_digit(input logic [CHAR_W-1:0] c);
		logic [BASE_W-1:0]       d;
		logic [VALUE_W+BASE_W:0] wide;
		d = digit_of(c);
		if (radix < 2 || d >= radix) begin
			scan = SCAN_REST;
			return;
		end
		got_digit = 1'b1;
		stop_pos = pos_after(char_pos);
		scan = SCAN_DIGITS;
		if (!ovf) begin
			wide = acc * radix + d;
			if (wide[VALUE_W+BASE_W:VALUE_W] != 0)
				ovf = 1'b1;
			acc = wide[VALUE_W-1:0];
		end
	endtask

	task automatic after_sign(input logic [CHAR_W-1:0] c);
		if (bad_radix(radix)) begin
			scan = SCAN_REST;
		end else if (radix == 0) begin
			if (c == "0") begin
				got_digit = 1'b1;
				stop_pos = pos_after(char_pos);
				scan = SCAN_ZERO;
			end else begin
				radix = BASE_DEC;
				take_digit(c);
			end
		end else begin
			take_digit(c);
		end
	endtask

	task automatic parse_char(input logic [CHAR_W-1:0] c);
		logic [BASE_W-1:0] b;
		res_t              w;
		if (c == END_OF_TEXT) begin
			b = (scan == SCAN_LEAD) ? base_reg : radix;
			w.value = '0;
			w.status = ST_OK;
			w.digits = 1'b0;
			w.stop = '0;
			if (bad_radix(b)) begin
				w.status = ST_BAD_BASE;
			end else if (ovf) begin
				w.status = ST_OVERFLOW;
				w.digits = 1'b1;
				w.stop = stop_pos;
			end else if (got_digit) begin
				w.value = neg ? ~acc + 1'b1 : acc;
				w.digits = 1'b1;
				w.stop = stop_pos;
			end
			words_due.push_back(w);
			clear_text();
			return;
		end
		case (scan)
			SCAN_LEAD: begin
				if (!is_blank(c)) begin
					radix = base_reg;
					if (c == "-") begin
						neg = 1'b1;
						scan = SCAN_SIGN;
					end else if (c == "+") begin
						scan = SCAN_SIGN;
					end else begin
						after_sign(c);
					end
				end
			end
			SCAN_SIGN: after_sign(c);
			SCAN_ZERO: begin
				if (c == "x" || c == "X") begin
					radix = BASE_HEX;
					scan = SCAN_DIGITS;
				end else begin
					radix = BASE_OCT;
					take_digit(c);
				end
			end
			SCAN_DIGITS: take_digit(c);
			default: ;
		endcase
		char_pos = pos_after(char_pos);
	endtask

	task automatic compare_word();
		res_t w;
		if (words_due.size() == 0) begin
			$error("result word with no string pending: value %h status %0d",
				parsed_value, status);
			fails++;
			return;
		end
		w = words_due.pop_front();
		checked++;
		if (parsed_value !== w.value) begin
			$error("parsed_value: expected %h, got %h", w.value, parsed_value);
			fails++;
		end
		if (status !== w.status) begin
			$error("status: expected %0d, got %0d", w.status, status);
			fails++;
		end
		if (digits_found !== w.digits) begin
			$error("digits_found: expected %0d, got %0d", w.digits, digits_found);
			fails++;
		end
		if (stop_offset !== w.stop) begin
			$error("stop_offset: expected %0d, got %0d", w.stop, stop_offset);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = '0;
			clear_text();
			words_due.delete();
			fails = 0;
			checked = 0;
			pending_count <= 0;
			fail_count <= 0;
			result_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				base_reg = number_base;
			if (pop && !empty)
				compare_word();
			if (push && !full)
				parse_char(char_code);
			pending_count <= words_due.size();
			fail_count <= fails;
			result_count <= checked;
		end
	end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// testbench for the text to u64 parser core
// ----------------------------------------------------------------------------
// Drives strings into the core in bursts with random gaps, and pops results on
// a stall pattern of its own. A short directed set comes first. It covers the
// empty string, sign only, hex, octal and bare 0x prefixes, high bytes and the
// all-ones value. Random strings follow under a series of radix settings:
// auto, 2, 8, 10, 16, 36, bad ones and a random one. Most strings are
// well-formed: blanks, sign, prefix, digits of the radix and an ignored tail.
// The rest is noise. t64p_checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;

	import t64p_pkg::*;

	localparam int LIMIT = 500000;
	localparam int SETTLE = 8;
	localparam int PHASE_CHARS = 42;
	localparam logic [CHAR_W-1:0] END_OF_TEXT = '0;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	logic [CHAR_W-1:0]   char_code;
	logic                empty;
	logic                pop;
	logic [VALUE_W-1:0]  parsed_value;
	logic [STATUS_W-1:0] status;
	logic                digits_found;
	logic [POS_W-1:0]    stop_offset;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [BASE_W-1:0]   number_base;

	int pending_count;
	int fail_count;
	int result_count;
	int cycle_count = 0;
	int burst_left = 0;
	int chars_sent = 0;
	int bases_used = 0;
	int rx_mode = 0;
	int rx_left = 0;
	logic [CHAR_W-1:0] text_q[$];

	text_to_u64_parser_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.parsed_value(parsed_value),
		.status(status),
		.digits_found(digits_found),
		.stop_offset(stop_offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.number_base(number_base)
	);

	t64p_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.parsed_value(parsed_value),
		.status(status),
		.digits_found(digits_found),
		.stop_offset(stop_offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.number_base(number_base),
		.pending_count(pending_count),
		.fail_count(fail_count),
		.result_count(result_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("FAIL text_to_u64_parser_core");
			$finish;
		end
	end

	// result side stall pattern
	initial begin
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(20, 200);
			end
			rx_left--;
			case (rx_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 1) == 1);
				2: pop <= ($urandom_range(0, 7) == 0);
				default: pop <= (rx_left % 24) >= 20;
			endcase
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c);
		push <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (full);
		chars_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_char(text_q[i]);
		send_char(END_OF_TEXT);
	endtask

	task automatic load_text(input string s);
		text_q.delete();
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_base(input logic [BASE_W-1:0] b);
		wait_idle();
		cfg_valid <= 1'b1;
		number_base <= b;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		bases_used++;
	endtask

	function automatic logic [CHAR_W-1:0] digit_char(input int v);
		if (v < 10)
			return CHAR_W'("0" + v);
		return ($urandom_range(0, 1) == 1) ? CHAR_W'("a" + v - 10) : CHAR_W'("A" + v - 10);
	endfunction

	function automatic void build_text(input logic [BASE_W-1:0] b);
		int k;
		int r;
		int n;
		text_q.delete();
		if ($urandom_range(0, 9) < 2) begin
			repeat ($urandom_range(0, 8))
				text_q.push_back(CHAR_W'($urandom_range(1, 255)));
			return;
		end
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(0, 5);
			text_q.push_back((k == 5) ? CHAR_W'(" ") : CHAR_W'("\t" + k));
		end
		case ($urandom_range(0, 3))
			0: text_q.push_back("-");
			1: text_q.push_back("+");
			default: ;
		endcase
		r = b;
		if (b == 0) begin
			case ($urandom_range(0, 2))
				0: begin
					text_q.push_back("0");
					text_q.push_back(($urandom_range(0, 1) == 1) ? "x" : "X");
					r = BASE_HEX;
				end
				1: begin
					text_q.push_back("0");
					r = BASE_OCT;
				end
				default: r = BASE_DEC;
			endcase
		end else if (b == 1 || b > MAX_BASE) begin
			r = BASE_DEC;
		end
		if ($urandom_range(0, 19) == 0)
			n = 0;
		else if ($urandom_range(0, 9) < 7)
			n = $urandom_range(1, 12);
		else
			n = $urandom_range(13, 24);
		repeat (n)
			text_q.push_back(digit_char($urandom_range(0, r - 1)));
		if ($urandom_range(0, 1) == 1)
			repeat ($urandom_range(1, 4))
				text_q.push_back(CHAR_W'($urandom_range(1, 255)));
	endfunction

	initial begin
		logic [BASE_W-1:0] bases[];
		int phase_start;
		bases = '{6'd0, 6'd10, 6'd16, 6'd8, 6'd2, 6'd36,
			6'd1, 6'd37, 6'd63, 6'd0, 6'd0};
		arst_n <= 1'b0;
		push <= 1'b0;
		char_code <= '0;
		cfg_valid <= 1'b0;
		number_base <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		write_base(6'd0);
		load_text("");
		send_text();
		load_text("\t-0x1F");
		send_text();
		load_text("0x");
		send_text();
		load_text("09z");
		send_text();
		load_text("+");
		send_text();
		load_text("\377");
		send_text();
		load_text("-1");
		send_text();

		bases[9] = BASE_W'($urandom_range(3, 35));
		foreach (bases[p]) begin
			write_base(bases[p]);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_CHARS) begin
				build_text(bases[p]);
				send_text();
			end
		end

		wait_idle();
		$display("sent %0d characters under %0d radix settings, checked %0d result words",
			chars_sent, bases_used, result_count);
		$display("covered auto prefixes, signs, overflow, bad radix and noisy strings");
		if (fail_count == 0)
			$display("PASS text_to_u64_parser_core");
		else
			$display("FAIL text_to_u64_parser_core");
		$finish;
	end

endmodule
